>>> rtl/core/fcmh_pkg.sv
// Shared types, constants and codes for the free chunk max-heap.
package fcmh_pkg;

   localparam int HEAP_ENTRIES    = 16;
   localparam int IDX_W           = $clog2(HEAP_ENTRIES);
   localparam int CNT_W           = $clog2(HEAP_ENTRIES + 1);
   localparam int LEN_W           = 32;
   localparam int BASE_W          = 48;
   localparam int VOL_W           = 36;
   localparam logic [LEN_W-1:0] MIN_REUSE_RESET = 32'd256;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_TAKE  = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

   // Response kinds
   typedef enum logic [1:0] {
      KIND_GRANT   = 2'd0,
      KIND_DISCARD = 2'd1,
      KIND_MISS    = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [LEN_W-1:0]  needed_length;
      logic              chunk_valid;
      logic [BASE_W-1:0] chunk_base;
      logic [LEN_W-1:0]  chunk_length;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [BASE_W-1:0] result_base;
      logic [LEN_W-1:0]  result_length;
      logic [CNT_W-1:0]  entry_count;
      logic [VOL_W-1:0]  total_volume;
      logic              last;
   } rsp_type;

   // Datapath register updates
   typedef enum logic [3:0] {
      DP_NONE,
      DP_APPEND,
      DP_SCAN_INIT,
      DP_SCAN_STEP,
      DP_EVICT,
      DP_HIT_KEEP,
      DP_TAKE_ROOT,
      DP_LOAD_LAST,
      DP_SU_MOVE,
      DP_SD_MOVE
   } dp_op_type;

   // Heap read address selection
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_PARENT,
      RD_CHILD,
      RD_SCAN,
      RD_COUNT
   } rd_sel_type;

   // Heap write data selection
   typedef enum logic [1:0] {
      WR_X,
      WR_PARENT,
      WR_CHILD
   } wr_sel_type;

   // Chunk shown on a response
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_CHUNK,
      SRC_HELD
   } src_type;

   typedef struct packed {
      logic       load_req;
      dp_op_type  dp_op;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       emit;
      kind_type   emit_kind;
      src_type    emit_src;
      logic       emit_last;
      logic       emit_zero;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       chunk_valid;
      logic       short_chunk;
      logic       full;
      logic       empty;
      logic       hit;
      logic       at_root;
      logic       su_stop;
      logic       sd_leaf;
      logic       sd_stop;
      logic       scan_end;
      logic       slot_free;
   } status_type;

endpackage

>>> rtl/core/fcmh_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module fcmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write one entry, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/core/fcmh_datapath.sv
// Heap storage, count, volume, sift registers and response register.
module fcmh_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fcmh_pkg::req_type    req_data,
   output fcmh_pkg::rsp_type    rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   input  fcmh_pkg::cmd_type    cmd,
   output fcmh_pkg::status_type status
);

   localparam int IW = fcmh_pkg::IDX_W;
   localparam int CW = fcmh_pkg::CNT_W;
   localparam int VW = fcmh_pkg::VOL_W;

   fcmh_pkg::req_type   req_ff;
   fcmh_pkg::entry_type x_ff;
   fcmh_pkg::entry_type x_in;
   fcmh_pkg::entry_type held_ff;
   fcmh_pkg::entry_type held_in;
   fcmh_pkg::entry_type best_ff;
   fcmh_pkg::entry_type best_in;
   fcmh_pkg::entry_type rd_a;
   fcmh_pkg::entry_type rd_b;
   fcmh_pkg::entry_type chunk;
   fcmh_pkg::entry_type child;
   fcmh_pkg::entry_type wr_data;
   fcmh_pkg::rsp_type   rsp_ff;
   fcmh_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [31:0]         min_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [VW-1:0]       vol_ff;
   logic [VW-1:0]       vol_in;
   logic [IW-1:0]       pos_ff;
   logic [IW-1:0]       pos_in;
   logic [IW-1:0]       scan_ff;
   logic [IW-1:0]       scan_in;
   logic [IW-1:0]       best_idx_ff;
   logic [IW-1:0]       best_idx_in;
   logic [IW-1:0]       parent;
   logic [IW-1:0]       addr_a;
   logic [IW-1:0]       addr_b;
   logic [CW-1:0]       pos_c;
   logic [CW-1:0]       l_full;
   logic [CW-1:0]       r_full;
   logic                pick_r;
   logic                slot_free;

   assign chunk.base   = req_ff.chunk_base;
   assign chunk.length = req_ff.chunk_length;
   assign pos_c        = CW'(pos_ff);
   assign l_full       = (pos_c << 1) + CW'(1);
   assign r_full       = l_full + CW'(1);
   assign parent       = IW'((pos_ff - IW'(1)) >> 1);
   assign pick_r       = (r_full < count_ff) && (rd_a.length < rd_b.length);
   assign child        = pick_r ? rd_b : rd_a;
   assign slot_free    = !rsp_valid_ff || rsp_ready;

   // select read addresses
   always_comb begin
      addr_a = '0;
      addr_b = '0;
      case (cmd.rd_sel)
         fcmh_pkg::RD_ZERO:   addr_a = '0;
         fcmh_pkg::RD_PARENT: addr_a = parent;
         fcmh_pkg::RD_CHILD: begin
            addr_a = l_full[IW-1:0];
            addr_b = r_full[IW-1:0];
         end
         fcmh_pkg::RD_SCAN:   addr_a = scan_ff;
         fcmh_pkg::RD_COUNT:  addr_a = count_ff[IW-1:0];
         default:             addr_a = '0;
      endcase
   end

   // select write data
   always_comb begin
      case (cmd.wr_sel)
         fcmh_pkg::WR_X:      wr_data = x_ff;
         fcmh_pkg::WR_PARENT: wr_data = rd_a;
         fcmh_pkg::WR_CHILD:  wr_data = child;
         default:             wr_data = x_ff;
      endcase
   end

   fcmh_ram #(
      .WIDTH($bits(fcmh_pkg::entry_type)),
      .DEPTH(fcmh_pkg::HEAP_ENTRIES)
   ) u_heap (
      .clock     (clock),
      .wr_en     (cmd.wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // register updates per command
   always_comb begin
      count_in    = count_ff;
      vol_in      = vol_ff;
      pos_in      = pos_ff;
      x_in        = x_ff;
      held_in     = held_ff;
      scan_in     = scan_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      case (cmd.dp_op)
         fcmh_pkg::DP_APPEND: begin
            pos_in   = count_ff[IW-1:0];
            count_in = count_ff + CW'(1);
            vol_in   = vol_ff + VW'(chunk.length);
            x_in     = chunk;
         end
         fcmh_pkg::DP_SCAN_INIT: scan_in = IW'(fcmh_pkg::HEAP_ENTRIES - 1);
         fcmh_pkg::DP_SCAN_STEP: begin
            if (scan_ff == IW'(fcmh_pkg::HEAP_ENTRIES - 1) || rd_a.length < best_ff.length) begin
               best_in     = rd_a;
               best_idx_in = scan_ff;
            end
            scan_in = scan_ff - IW'(1);
         end
         fcmh_pkg::DP_EVICT: begin
            held_in = best_ff;
            vol_in  = vol_ff - VW'(best_ff.length) + VW'(chunk.length);
            pos_in  = best_idx_ff;
            x_in    = chunk;
         end
         fcmh_pkg::DP_HIT_KEEP: begin
            held_in = rd_a;
            vol_in  = vol_ff - VW'(rd_a.length) + VW'(chunk.length);
            pos_in  = '0;
            x_in    = chunk;
         end
         fcmh_pkg::DP_TAKE_ROOT: begin
            held_in  = rd_a;
            vol_in   = vol_ff - VW'(rd_a.length);
            count_in = count_ff - CW'(1);
         end
         fcmh_pkg::DP_LOAD_LAST: begin
            x_in   = rd_a;
            pos_in = '0;
         end
         fcmh_pkg::DP_SU_MOVE: pos_in = parent;
         fcmh_pkg::DP_SD_MOVE: pos_in = pick_r ? r_full[IW-1:0] : l_full[IW-1:0];
         default: ;
      endcase
   end

   // build the next response
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit && slot_free) begin
         rsp_valid_in         = 1'b1;
         rsp_in.result_kind   = cmd.emit_kind;
         rsp_in.result_base   = '0;
         rsp_in.result_length = '0;
         case (cmd.emit_src)
            fcmh_pkg::SRC_CHUNK: begin
               rsp_in.result_base   = chunk.base;
               rsp_in.result_length = chunk.length;
            end
            fcmh_pkg::SRC_HELD: begin
               rsp_in.result_base   = held_ff.base;
               rsp_in.result_length = held_ff.length;
            end
            default: ;
         endcase
         rsp_in.entry_count  = cmd.emit_zero ? '0 : count_ff;
         rsp_in.total_volume = cmd.emit_zero ? '0 : vol_ff;
         rsp_in.last         = cmd.emit_last;
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         vol_ff       <= '0;
         min_ff       <= fcmh_pkg::MIN_REUSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         vol_ff       <= vol_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            min_ff <= csr_write_data;
         end
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      pos_ff      <= pos_in;
      x_ff        <= x_in;
      held_ff     <= held_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.op          = req_ff.operation;
   assign status.chunk_valid = req_ff.chunk_valid;
   assign status.short_chunk = req_ff.chunk_length <= min_ff;
   assign status.full        = count_ff >= CW'(fcmh_pkg::HEAP_ENTRIES);
   assign status.empty       = count_ff == '0;
   assign status.hit         = (count_ff != '0) && (rd_a.length >= req_ff.needed_length);
   assign status.at_root     = pos_ff == '0;
   assign status.su_stop     = x_ff.length < rd_a.length;
   assign status.sd_leaf     = pos_c >= (count_ff >> 1);
   assign status.sd_stop     = !(x_ff.length < child.length);
   assign status.scan_end    = scan_ff == IW'(fcmh_pkg::HEAP_ENTRIES / 2 + 1);
   assign status.slot_free   = slot_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(fcmh_pkg::HEAP_ENTRIES))
      else $error("heap count beyond capacity");

   a_empty_no_volume: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (vol_ff == '0))
      else $error("volume left on an empty heap");

   a_no_write_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> !cmd.wr_en)
      else $error("heap written while taking a request");

endmodule

>>> rtl/core/fcmh_ctrl.sv
// Sequencer for add, take and flush requests over the heap datapath.
module fcmh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fcmh_pkg::status_type status,
   output fcmh_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_ADD, S_SCAN_RD, S_SCAN_CMP, S_EVICT, S_EMIT_EVICT,
      S_SU_RD, S_SU_CMP, S_TK_RD, S_TK_CHK, S_EMIT_RESID, S_POP_RD, S_POP_LD,
      S_SD_RD, S_SD_CMP, S_EMIT_GRANT, S_FL_RD, S_FL_TAKE, S_EMIT_FLUSH,
      S_EMIT_MISS, S_EMIT_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      hit_ff, hit_in;
   logic      evicted_ff, evicted_in;
   state_type add_exit;
   state_type sd_exit;
   logic      is_add;

   assign is_add   = status.op == fcmh_pkg::OP_ADD;
   assign add_exit = is_add ? (evicted_ff ? S_IDLE : S_EMIT_DONE) : S_EMIT_MISS;
   assign sd_exit  = (status.op == fcmh_pkg::OP_TAKE) ? S_EMIT_GRANT : S_EMIT_FLUSH;
   assign req_ready = state_ff == S_IDLE;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      hit_in        = hit_ff;
      evicted_in    = evicted_ff;
      cmd           = '0;
      cmd.dp_op     = fcmh_pkg::DP_NONE;
      cmd.rd_sel    = fcmh_pkg::RD_ZERO;
      cmd.wr_sel    = fcmh_pkg::WR_X;
      cmd.emit_kind = fcmh_pkg::KIND_DONE;
      cmd.emit_src  = fcmh_pkg::SRC_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            hit_in     = 1'b0;
            evicted_in = 1'b0;
            if (status.op == fcmh_pkg::OP_ADD) begin
               state_in = status.chunk_valid ? S_ADD : S_EMIT_DONE;
            end else if (status.op == fcmh_pkg::OP_TAKE) begin
               state_in = S_TK_RD;
            end else if (status.op == fcmh_pkg::OP_FLUSH && !status.empty) begin
               state_in = S_FL_RD;
            end else begin
               state_in = S_EMIT_DONE;
            end
         end
         S_ADD: begin
            if (status.short_chunk) begin
               state_in = S_EMIT_RESID;
            end else if (!status.full) begin
               cmd.dp_op = fcmh_pkg::DP_APPEND;
               state_in  = S_SU_RD;
            end else begin
               cmd.dp_op = fcmh_pkg::DP_SCAN_INIT;
               state_in  = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_sel = fcmh_pkg::RD_SCAN;
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.dp_op = fcmh_pkg::DP_SCAN_STEP;
            state_in  = status.scan_end ? S_EVICT : S_SCAN_RD;
         end
         S_EVICT: begin
            cmd.dp_op  = fcmh_pkg::DP_EVICT;
            evicted_in = 1'b1;
            state_in   = S_EMIT_EVICT;
         end
         S_EMIT_EVICT: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = fcmh_pkg::KIND_DISCARD;
            cmd.emit_src  = fcmh_pkg::SRC_HELD;
            cmd.emit_last = is_add;
            if (status.slot_free) begin
               state_in = S_SU_RD;
            end
         end
         S_SU_RD: begin
            if (status.at_root) begin
               cmd.wr_en = 1'b1;
               state_in  = add_exit;
            end else begin
               cmd.rd_sel = fcmh_pkg::RD_PARENT;
               state_in   = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.su_stop) begin
               state_in = add_exit;
            end else begin
               cmd.wr_sel = fcmh_pkg::WR_PARENT;
               cmd.dp_op  = fcmh_pkg::DP_SU_MOVE;
               state_in   = S_SU_RD;
            end
         end
         S_TK_RD: begin
            cmd.rd_sel = fcmh_pkg::RD_ZERO;
            state_in   = S_TK_CHK;
         end
         S_TK_CHK: begin
            if (status.hit) begin
               hit_in = 1'b1;
               if (status.chunk_valid && !status.short_chunk) begin
                  cmd.dp_op = fcmh_pkg::DP_HIT_KEEP;
                  state_in  = S_SD_RD;
               end else begin
                  cmd.dp_op = fcmh_pkg::DP_TAKE_ROOT;
                  state_in  = status.chunk_valid ? S_EMIT_RESID : S_POP_RD;
               end
            end else begin
               state_in = status.chunk_valid ? S_ADD : S_EMIT_MISS;
            end
         end
         S_EMIT_RESID: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = fcmh_pkg::KIND_DISCARD;
            cmd.emit_src  = fcmh_pkg::SRC_CHUNK;
            cmd.emit_last = is_add;
            if (status.slot_free) begin
               state_in = is_add ? S_IDLE : (hit_ff ? S_POP_RD : S_EMIT_MISS);
            end
         end
         S_POP_RD: begin
            cmd.rd_sel = fcmh_pkg::RD_COUNT;
            state_in   = S_POP_LD;
         end
         S_POP_LD: begin
            cmd.dp_op = fcmh_pkg::DP_LOAD_LAST;
            state_in  = S_SD_RD;
         end
         S_SD_RD: begin
            if (status.sd_leaf) begin
               cmd.wr_en = 1'b1;
               state_in  = sd_exit;
            end else begin
               cmd.rd_sel = fcmh_pkg::RD_CHILD;
               state_in   = S_SD_CMP;
            end
         end
         S_SD_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.sd_stop) begin
               state_in = sd_exit;
            end else begin
               cmd.wr_sel = fcmh_pkg::WR_CHILD;
               cmd.dp_op  = fcmh_pkg::DP_SD_MOVE;
               state_in   = S_SD_RD;
            end
         end
         S_EMIT_GRANT: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = fcmh_pkg::KIND_GRANT;
            cmd.emit_src  = fcmh_pkg::SRC_HELD;
            cmd.emit_last = 1'b1;
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_FL_RD: begin
            cmd.rd_sel = fcmh_pkg::RD_ZERO;
            state_in   = S_FL_TAKE;
         end
         S_FL_TAKE: begin
            cmd.dp_op = fcmh_pkg::DP_TAKE_ROOT;
            state_in  = S_POP_RD;
         end
         S_EMIT_FLUSH: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = fcmh_pkg::KIND_DISCARD;
            cmd.emit_src  = fcmh_pkg::SRC_HELD;
            cmd.emit_last = status.empty;
            cmd.emit_zero = 1'b1;
            if (status.slot_free) begin
               state_in = status.empty ? S_IDLE : S_FL_RD;
            end
         end
         S_EMIT_MISS: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = fcmh_pkg::KIND_MISS;
            cmd.emit_last = 1'b1;
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT_DONE: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = fcmh_pkg::KIND_DONE;
            cmd.emit_last = 1'b1;
            if (status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         hit_ff     <= 1'b0;
         evicted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hit_ff     <= hit_in;
         evicted_ff <= evicted_in;
      end
   end

endmodule

>>> rtl/core/free_chunk_max_heap.sv
// Top level of the free chunk max-heap: controller, datapath and heap memory.
//
// Usage:
//  - req_ channel (valid/ready) carries one request: add a chunk, take a chunk
//    of at least needed_length, or flush every held chunk.
//  - rsp_ channel (valid/ready) returns one or more responses per request,
//    the final one marked by last; entry_count and total_volume show the heap
//    after the whole request.
//  - csr_write_enable/csr_write_data set the reuse threshold; write only when
//    the block is idle.
// Timing: one request at a time; req_ready is high only between requests.
//  A full-heap add runs a seven-leaf scan for the shortest leaf, then a
//  sift-up; a take with pop sifts down; a flush pops every held entry in
//  turn. Each scan and sift step is bounded by the single heap memory,
//  whose read data is registered, so a read state precedes each compare.
// Reset: synchronous; the heap empties, volume clears, threshold returns to
//  256. Heap contents need no clearing.
// Stall: a response register decouples the output; while the receiver holds
//  rsp_ready low the sequencer waits before loading the next response.
module free_chunk_max_heap (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fcmh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fcmh_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data
);

   fcmh_pkg::cmd_type    cmd;
   fcmh_pkg::status_type status;

   fcmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcmh_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> dv/tb_free_chunk_max_heap.sv
// Self-checking testbench for the free chunk max-heap: directed and random requests.
module tb_free_chunk_max_heap;
   import fcmh_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   // Predicted heap contents and threshold
   logic [LEN_W-1:0]  pred_len [HEAP_ENTRIES];
   logic [BASE_W-1:0] pred_base [HEAP_ENTRIES];
   int unsigned       pred_count;
   logic [VOL_W-1:0]  pred_volume;
   logic [LEN_W-1:0]  reuse_limit;

   rsp_type expected_rsps [$];
   rsp_type step_rsps [$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   free_chunk_max_heap dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // Watchdog
   initial begin
      #8000000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void note_rsp(kind_type kind, logic [BASE_W-1:0] base,
                                    logic [LEN_W-1:0] len);
      rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.result_base = base;
      r.result_length = len;
      step_rsps.push_back(r);
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [LEN_W-1:0]  tl;
      logic [BASE_W-1:0] tb;
      tl = pred_len[a]; tb = pred_base[a];
      pred_len[a] = pred_len[b]; pred_base[a] = pred_base[b];
      pred_len[b] = tl; pred_base[b] = tb;
   endfunction

   function automatic void sift_towards_root(int pos);
      int parent;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (pred_len[pos] < pred_len[parent]) break;
         swap_slots(pos, parent);
         pos = parent;
      end
   endfunction

   function automatic void sift_from_root();
      int pos, l, r, nx;
      pos = 0;
      while (pos < int'(pred_count / 2)) begin
         l = 2 * pos + 1;
         r = l + 1;
         nx = (r < int'(pred_count) && pred_len[l] < pred_len[r]) ? r : l;
         if (pred_len[pos] < pred_len[nx]) begin
            swap_slots(pos, nx);
            pos = nx;
         end else break;
      end
   endfunction

   function automatic void insert_chunk(logic valid, logic [BASE_W-1:0] base,
                                        logic [LEN_W-1:0] len);
      int leaf, i;
      if (!valid) return;
      if (len <= reuse_limit) begin
         note_rsp(KIND_DISCARD, base, len);
         return;
      end
      if (pred_count >= HEAP_ENTRIES) begin
         leaf = HEAP_ENTRIES - 1;
         for (i = HEAP_ENTRIES - 2; i > HEAP_ENTRIES / 2; i--)
            if (pred_len[i] < pred_len[leaf]) leaf = i;
         note_rsp(KIND_DISCARD, pred_base[leaf], pred_len[leaf]);
         pred_volume = pred_volume - VOL_W'(pred_len[leaf]);
      end else begin
         leaf = pred_count;
         pred_count++;
      end
      pred_len[leaf] = len;
      pred_base[leaf] = base;
      pred_volume = pred_volume + VOL_W'(len);
      sift_towards_root(leaf);
   endfunction

   function automatic void remove_root();
      pred_volume = pred_volume - VOL_W'(pred_len[0]);
      pred_count--;
      pred_len[0] = pred_len[pred_count];
      pred_base[0] = pred_base[pred_count];
      sift_from_root();
   endfunction

   // Work out the responses of one request and queue them
   function automatic void predict_heap_step(req_type rq);
      logic [LEN_W-1:0]  glen;
      logic [BASE_W-1:0] gbase;
      logic keep;
      step_rsps.delete();
      if (rq.operation == OP_ADD) begin
         insert_chunk(rq.chunk_valid, rq.chunk_base, rq.chunk_length);
         if (step_rsps.size() == 0) note_rsp(KIND_DONE, '0, '0);
      end else if (rq.operation == OP_TAKE) begin
         if (pred_count > 0 && pred_len[0] >= rq.needed_length) begin
            glen = pred_len[0];
            gbase = pred_base[0];
            keep = rq.chunk_valid;
            if (keep && rq.chunk_length <= reuse_limit) begin
               note_rsp(KIND_DISCARD, rq.chunk_base, rq.chunk_length);
               keep = 1'b0;
            end
            if (keep) begin
               pred_volume = pred_volume - VOL_W'(glen) + VOL_W'(rq.chunk_length);
               pred_len[0] = rq.chunk_length;
               pred_base[0] = rq.chunk_base;
               sift_from_root();
            end else remove_root();
            note_rsp(KIND_GRANT, gbase, glen);
         end else begin
            insert_chunk(rq.chunk_valid, rq.chunk_base, rq.chunk_length);
            note_rsp(KIND_MISS, '0, '0);
         end
      end else if (rq.operation == OP_FLUSH && pred_count > 0) begin
         while (pred_count > 0) begin
            glen = pred_len[0];
            gbase = pred_base[0];
            remove_root();
            note_rsp(KIND_DISCARD, gbase, glen);
         end
      end else note_rsp(KIND_DONE, '0, '0);
      foreach (step_rsps[k]) begin
         step_rsps[k].entry_count = CNT_W'(pred_count);
         step_rsps[k].total_volume = pred_volume;
         step_rsps[k].last = (k == step_rsps.size() - 1);
         expected_rsps.push_back(step_rsps[k]);
      end
   endfunction

   // Send one request, holding it until accepted
   task automatic send_request(logic [1:0] op, logic [31:0] need, logic valid,
                               logic [47:0] base, logic [31:0] len);
      req_type rq;
      rq.operation = op;
      rq.needed_length = need;
      rq.chunk_valid = valid;
      rq.chunk_base = base;
      rq.chunk_length = len;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_data <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_heap_step(rq);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait for the block to drain, then write the threshold
   task automatic write_threshold(logic [31:0] value);
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      reuse_limit = value;
   endtask

   // Receiver stall pattern
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: expected %h actual %h", $time, want, rsp_data);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_len();
      case ($urandom_range(5))
         0: return $urandom_range(300);
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_TAKE, 0, 0, 0, 0);            // take on empty heap
      send_request(OP_FLUSH, 0, 0, 0, 0);           // flush on empty heap
      send_request(2'd3, 32'hFFFF_FFFF, 1, '1, '1); // unused operation code
      send_request(OP_ADD, 0, 0, '1, '1);           // add without chunk
      send_request(OP_ADD, 0, 1, 48'h1234, 0);      // zero length is short
      send_request(OP_ADD, 0, 1, 48'h5678, 256);    // at threshold is short
      send_request(OP_ADD, '1, 1, '1, '1);
      send_request(OP_ADD, 0, 1, 48'h1, 257);
      send_request(OP_TAKE, '1, 1, 48'h99, 5);      // hit, short residual dropped
      send_request(OP_TAKE, '1, 1, 48'h77, 1000);   // miss, residual added
      send_request(OP_TAKE, 300, 1, 48'h66, 900);   // hit, residual kept
      for (int i = 0; i < 17; i++)                  // fill and overflow the heap
         send_request(OP_ADD, 0, 1, 48'h1000 + i, 32'd400 + (i % 5));
      send_request(OP_ADD, 0, 1, 48'hABC, 260);     // full: shorter still replaces
      send_request(OP_FLUSH, 0, 0, 0, 0);
   endtask

   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 55)
            send_request(OP_ADD, $urandom, $urandom_range(9) != 0,
                         48'({$urandom, $urandom}), rand_len());
         else if (r < 92)
            send_request(OP_TAKE, rand_len(), 1'($urandom_range(1)),
                         48'({$urandom, $urandom}), rand_len());
         else if (r < 98)
            send_request(OP_FLUSH, $urandom, 1'($urandom_range(1)),
                         48'({$urandom, $urandom}), $urandom);
         else
            send_request(2'd3, $urandom, 1'($urandom_range(1)),
                         48'({$urandom, $urandom}), $urandom);
      end
   endtask

   initial begin
      reuse_limit = MIN_REUSE_RESET;
      pred_count = 0;
      pred_volume = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 24; recv_idle_pct = 67;
      test_directed();
      test_random(150);
      write_threshold(32'd0);
      test_random(60);
      write_threshold(32'hFFFF_FFFF);
      test_directed();

      send_idle_pct = 67; recv_idle_pct = 24;
      write_threshold(32'hFFFF_FFFE);
      test_random(30);
      write_threshold(32'h8000_0000);
      test_random(130);

      send_idle_pct = 0; recv_idle_pct = 0;
      write_threshold(32'd1);
      test_random(130);

      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
